// ===== hw/rtl/baa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package baa_pkg;

  // Sequencer states of the back end.
  typedef enum logic [3:0] {
    S_IDLE,
    S_RR,
    S_XX,
    S_DEN,
    S_GO,
    S_WAIT,
    S_ADJ,
    S_TAP,
    S_ACC,
    S_EMIT
  } state_t;

  // Which quotient the shared divider is working on.
  typedef enum logic [1:0] {
    DIV_RE,
    DIV_IM,
    DIV_TAP_RE,
    DIV_TAP_IM
  } div_sel_t;

  // Work that one element needs, decided when the word is accepted.
  typedef struct packed {
    logic recip;   // in service: needs -1/(r+jx)
    logic xfmr;    // in-service transformer
    logic tap;     // transformer seen from the from end: divide by tap squared
    logic shunt;   // in service with valid shunt data
    logic last;    // final element of the branch
  } cls_t;

  localparam int CLS_W = $bits(cls_t);

endpackage
`default_nettype wire

// ===== hw/rtl/branch_admittance_accumulator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Accumulates the pi-model admittance of one branch, one parallel element per input
// word, and gives one result word (series, transformer and shunt sums plus the
// saturation and zero-divisor flags) on the element marked last, then clears.
// A two-entry input queue takes words while the back end works. Cost per element
// is set by the shared restoring divider, by the number of quotients: none for an
// out-of-service element, up to two for an in-service element, and up to four for a
// transformer seen from its from end; a last element also passes the emit state.
// All values are signed fixed point with FRAC_BITS fraction bits; the tap ratio is
// unsigned and one bit narrower.
module branch_admittance_accumulator #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [WORD_WIDTH-1:0] resistance,
  input  wire  [WORD_WIDTH-1:0] reactance,
  input  wire  [WORD_WIDTH-1:0] charging,
  input  wire  [WORD_WIDTH-2:0] tap_ratio,
  input  wire  [WORD_WIDTH-1:0] shunt_conductance,
  input  wire  [WORD_WIDTH-1:0] shunt_susceptance,
  input  wire                   is_transformer,
  input  wire                   in_service,
  input  wire                   has_shunt,
  input  wire                   at_from_end,
  input  wire                   last_element,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [WORD_WIDTH-1:0] series_real,
  output logic [WORD_WIDTH-1:0] series_imag,
  output logic [WORD_WIDTH-1:0] xfmr_real,
  output logic [WORD_WIDTH-1:0] xfmr_imag,
  output logic [WORD_WIDTH-1:0] shunt_real,
  output logic [WORD_WIDTH-1:0] shunt_imag,
  output logic                  saturated,
  output logic                  zero_divisor
);
  import baa_pkg::*;

  logic                  q_valid;
  logic                  q_pop;
  cls_t                  q_cls;
  logic [WORD_WIDTH-1:0] q_r;
  logic [WORD_WIDTH-1:0] q_x;
  logic [WORD_WIDTH-1:0] q_hb;
  logic [WORD_WIDTH-2:0] q_tap;
  logic [WORD_WIDTH-1:0] q_g;
  logic [WORD_WIDTH-1:0] q_bsh;

  // Front end: accept, classify and queue elements.
  baa_front #(
    .W (WORD_WIDTH)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .resistance        (resistance),
    .reactance         (reactance),
    .charging          (charging),
    .tap_ratio         (tap_ratio),
    .shunt_conductance (shunt_conductance),
    .shunt_susceptance (shunt_susceptance),
    .is_transformer    (is_transformer),
    .in_service        (in_service),
    .has_shunt         (has_shunt),
    .at_from_end       (at_from_end),
    .last_element      (last_element),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_cls             (q_cls),
    .q_r               (q_r),
    .q_x               (q_x),
    .q_hb              (q_hb),
    .q_tap             (q_tap),
    .q_g               (q_g),
    .q_bsh             (q_bsh)
  );

  // Back end: reciprocals, tap division and the running sums.
  baa_back #(
    .W (WORD_WIDTH),
    .F (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_cls        (q_cls),
    .q_r          (q_r),
    .q_x          (q_x),
    .q_hb         (q_hb),
    .q_tap        (q_tap),
    .q_g          (q_g),
    .q_bsh        (q_bsh),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .series_real  (series_real),
    .series_imag  (series_imag),
    .xfmr_real    (xfmr_real),
    .xfmr_imag    (xfmr_imag),
    .shunt_real   (shunt_real),
    .shunt_imag   (shunt_imag),
    .saturated    (saturated),
    .zero_divisor (zero_divisor)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/baa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module baa_front #(
  parameter int W = 32
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  [W-1:0]         resistance,
  input  wire  [W-1:0]         reactance,
  input  wire  [W-1:0]         charging,
  input  wire  [W-2:0]         tap_ratio,
  input  wire  [W-1:0]         shunt_conductance,
  input  wire  [W-1:0]         shunt_susceptance,
  input  wire                  is_transformer,
  input  wire                  in_service,
  input  wire                  has_shunt,
  input  wire                  at_from_end,
  input  wire                  last_element,
  output logic                 q_valid,
  input  wire                  q_pop,
  output baa_pkg::cls_t        q_cls,
  output logic [W-1:0]         q_r,
  output logic [W-1:0]         q_x,
  output logic [W-1:0]         q_hb,
  output logic [W-2:0]         q_tap,
  output logic [W-1:0]         q_g,
  output logic [W-1:0]         q_bsh
);
  import baa_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int EW    = CLS_W + 6 * W - 1;

  cls_t          cls_in;
  logic [W:0]    hb_sum;
  logic [W-1:0]  hb_in;
  logic [EW-1:0] wr_entry;
  logic [EW-1:0] rd_entry;
  logic [EW-1:0] mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] cnt;
  logic          push;

  // Classify the element by the work it needs.
  always_comb begin
    cls_in.recip = in_service;
    cls_in.xfmr  = in_service & is_transformer;
    cls_in.tap   = in_service & is_transformer & at_from_end;
    cls_in.shunt = in_service & has_shunt;
    cls_in.last  = last_element;
  end

  // Half the line charging, truncated toward zero.
  assign hb_sum = {charging[W-1], charging} + {{W{1'b0}}, charging[W-1]};
  assign hb_in  = hb_sum[W:1];

  assign wr_entry = {cls_in, resistance, reactance, hb_in, tap_ratio,
                     shunt_conductance, shunt_susceptance};

  assign in_ready = (cnt != CW'(DEPTH));
  assign q_valid  = (cnt != '0);
  assign push     = in_valid & in_ready;

  // Short queue between the front and the back end.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !q_pop) begin
        cnt <= cnt + 1'b1;
      end else if (!push && q_pop) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign rd_entry = mem[rptr];
  assign q_cls    = cls_t'(rd_entry[EW-1 -: CLS_W]);
  assign q_r      = rd_entry[6*W-2 -: W];
  assign q_x      = rd_entry[5*W-2 -: W];
  assign q_hb     = rd_entry[4*W-2 -: W];
  assign q_tap    = rd_entry[3*W-2 -: W-1];
  assign q_g      = rd_entry[2*W-1 -: W];
  assign q_bsh    = rd_entry[W-1:0];

endmodule
`default_nettype wire

// ===== hw/rtl/baa_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module baa_div #(
  parameter int W  = 32,
  parameter int NW = 64,
  parameter int DW = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire  [NW-1:0]       num,
  input  wire  [DW-1:0]       den,
  input  wire                 neg,
  output logic                done,
  output logic [W-1:0]        quot,
  output logic                sat
);

  localparam int CPW  = (NW > DW + W) ? NW : DW + W;
  localparam int CNTW = $clog2(W + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   den_r;
  logic [W-1:0]    qsh;
  logic            neg_r;
  logic            ovf;
  logic [DW:0]     rem2;
  logic            ge;
  logic [DW:0]     rem_diff;
  logic            over;
  logic [W-1:0]    qmag;
  logic [W-1:0]    lim;

  // A quotient of 2^W or more is known to saturate before any step.
  assign ovf = CPW'(num) >= CPW'({den, {W{1'b0}}});

  // One restoring step: shift in the next numerator bit, try to subtract.
  assign rem2     = {rem, qsh[W-1]};
  assign ge       = rem2 >= {1'b0, den_r};
  assign rem_diff = rem2 - {1'b0, den_r};

  // Limit on the magnitude, one more for a negative result.
  assign lim  = neg_r ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign over = qsh[W-1] & (~neg_r | (|qsh[W-2:0]));
  assign qmag = over ? lim : qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (ovf) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CNTW'(W);
        end
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - 1'b1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath of the divider.
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= neg;
      den_r <= den;
      rem   <= DW'(num >> W);
      qsh   <= num[W-1:0];
      if (ovf) begin
        quot <= neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        sat  <= 1'b1;
      end
    end else if (busy) begin
      if (cnt != '0) begin
        rem <= ge ? rem_diff[DW-1:0] : rem2[DW-1:0];
        qsh <= {qsh[W-2:0], ge};
      end else begin
        quot <= neg_r ? W'(-qmag) : qmag;
        sat  <= over;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/baa_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module baa_back #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   q_valid,
  output logic                  q_pop,
  input  wire  baa_pkg::cls_t   q_cls,
  input  wire  [W-1:0]          q_r,
  input  wire  [W-1:0]          q_x,
  input  wire  [W-1:0]          q_hb,
  input  wire  [W-2:0]          q_tap,
  input  wire  [W-1:0]          q_g,
  input  wire  [W-1:0]          q_bsh,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [W-1:0]          series_real,
  output logic [W-1:0]          series_imag,
  output logic [W-1:0]          xfmr_real,
  output logic [W-1:0]          xfmr_imag,
  output logic [W-1:0]          shunt_real,
  output logic [W-1:0]          shunt_imag,
  output logic                  saturated,
  output logic                  zero_divisor
);
  import baa_pkg::*;

  localparam int NW = W + 2 * F;
  localparam int DW = 2 * W;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  state_t        state;
  state_t        state_next;
  div_sel_t      sel;
  cls_t          cls;
  logic [W-1:0]  r;
  logic [W-1:0]  x;
  logic [W-1:0]  hb;
  logic [W-2:0]  tap;
  logic [W-1:0]  g;
  logic [W-1:0]  bsh;
  logic [DW-1:0] rr;
  logic [DW-1:0] den_r;
  logic [W-1:0]  yre;
  logic [W-1:0]  yim;
  logic [W-1:0]  ser_re;
  logic [W-1:0]  ser_im;
  logic [W-1:0]  xf_re;
  logic [W-1:0]  xf_im;
  logic [W-1:0]  sh_re;
  logic [W-1:0]  sh_im;
  logic          flag_sat;
  logic          flag_zero;

  logic          div_start;
  logic          emit;
  logic [W-1:0]  mr;
  logic [W-1:0]  mx;
  logic [W-1:0]  mul_a;
  logic [DW-1:0] prod;
  logic [W-1:0]  div_mag;
  logic          div_neg;
  logic          div_done;
  logic [W-1:0]  div_quot;
  logic          div_sat;

  logic [W:0]    adj_t;
  logic [W:0]    sre_t;
  logic [W:0]    sim_t;
  logic [W:0]    xre_t;
  logic [W:0]    xim_t;
  logic [W:0]    ti_t;
  logic [W-1:0]  ti;
  logic [W:0]    hre_t;
  logic [W:0]    him_t;

  function automatic logic [W:0] ext(input logic [W-1:0] v);
    return {v[W-1], v};
  endfunction

  function automatic logic ovfw(input logic [W:0] v);
    return v[W] ^ v[W-1];
  endfunction

  function automatic logic [W-1:0] clampw(input logic [W:0] v);
    logic [W-1:0] res;
    if (v[W] ^ v[W-1]) begin
      res = v[W] ? WMIN : WMAX;
    end else begin
      res = v[W-1:0];
    end
    return res;
  endfunction

  function automatic logic [W-1:0] magw(input logic [W-1:0] v);
    return v[W-1] ? W'(-v) : v;
  endfunction

  function automatic logic [W-1:0] railw(input logic [W-1:0] v);
    logic [W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else begin
      res = v[W-1] ? WMIN : WMAX;
    end
    return res;
  endfunction

  assign mr = magw(r);
  assign mx = magw(x);

  // One squaring multiplier, shared by r, x and the tap.
  always_comb begin
    case (state)
      S_RR:    mul_a = mr;
      S_XX:    mul_a = mx;
      default: mul_a = {1'b0, tap};
    endcase
  end
  assign prod = mul_a * mul_a;

  // Operands of the shared divider.
  always_comb begin
    case (sel)
      DIV_RE: begin
        div_mag = mr;
        div_neg = ~r[W-1] & (r != '0);
      end
      DIV_IM: begin
        div_mag = mx;
        div_neg = x[W-1];
      end
      DIV_TAP_RE: begin
        div_mag = magw(yre);
        div_neg = yre[W-1];
      end
      default: begin
        div_mag = magw(yim);
        div_neg = yim[W-1];
      end
    endcase
  end

  baa_div #(
    .W  (W),
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({div_mag, {(2*F){1'b0}}}),
    .den   (den_r),
    .neg   (div_neg),
    .done  (div_done),
    .quot  (div_quot),
    .sat   (div_sat)
  );

  // Sums with one more bit, clamped on the way back to the word.
  assign adj_t = ext(yim) - ext(hb);
  assign sre_t = ext(ser_re) + ext(yre);
  assign sim_t = ext(ser_im) + ext(yim);
  assign xre_t = ext(xf_re) + ext(yre);
  assign xim_t = ext(xf_im) + ext(yim);
  assign ti_t  = ext(cls.xfmr ? '0 : hb) + ext(bsh);
  assign ti    = clampw(ti_t);
  assign hre_t = ext(sh_re) + ext(g);
  assign him_t = ext(sh_im) + ext(ti);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and strobes.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    emit       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = q_cls.recip ? S_RR : S_ACC;
        end
      end
      S_RR: begin
        state_next = S_XX;
      end
      S_XX: begin
        state_next = S_DEN;
      end
      S_DEN: begin
        if (r == '0 && x == '0) begin
          state_next = cls.xfmr ? S_ADJ : S_ACC;
        end else begin
          state_next = S_GO;
        end
      end
      S_GO: begin
        div_start  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          case (sel)
            DIV_RE:     state_next = S_GO;
            DIV_IM:     state_next = cls.xfmr ? S_ADJ : S_ACC;
            DIV_TAP_RE: state_next = S_GO;
            default:    state_next = S_ACC;
          endcase
        end
      end
      S_ADJ: begin
        state_next = cls.tap ? S_TAP : S_ACC;
      end
      S_TAP: begin
        state_next = (tap == '0) ? S_ACC : S_GO;
      end
      S_ACC: begin
        state_next = cls.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Element datapath and quotient registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cls <= q_cls;
      r   <= q_r;
      x   <= q_x;
      hb  <= q_hb;
      tap <= q_tap;
      g   <= q_g;
      bsh <= q_bsh;
      yre <= '0;
      yim <= '0;
    end
    case (state)
      S_RR: begin
        rr <= prod;
      end
      S_XX: begin
        den_r <= prod;
      end
      S_DEN: begin
        den_r <= rr + den_r;
        sel   <= DIV_RE;
      end
      S_WAIT: begin
        if (div_done) begin
          case (sel)
            DIV_RE: begin
              yre <= div_quot;
              sel <= DIV_IM;
            end
            DIV_IM: begin
              yim <= div_quot;
            end
            DIV_TAP_RE: begin
              yre <= div_quot;
              sel <= DIV_TAP_IM;
            end
            default: begin
              yim <= div_quot;
            end
          endcase
        end
      end
      S_ADJ: begin
        yim <= clampw(adj_t);
      end
      S_TAP: begin
        if (tap == '0) begin
          yre <= railw(yre);
          yim <= railw(yim);
        end else begin
          den_r <= prod;
          sel   <= DIV_TAP_RE;
        end
      end
      default: begin
      end
    endcase
  end

  // Running sums and sticky flags.
  always_ff @(posedge clk) begin
    if (rst || emit) begin
      ser_re    <= '0;
      ser_im    <= '0;
      xf_re     <= '0;
      xf_im     <= '0;
      sh_re     <= '0;
      sh_im     <= '0;
      flag_sat  <= 1'b0;
      flag_zero <= 1'b0;
    end else begin
      if (state == S_DEN && r == '0 && x == '0) begin
        flag_zero <= 1'b1;
      end
      if (state == S_TAP && tap == '0) begin
        flag_zero <= 1'b1;
      end
      if (state == S_WAIT && div_done && div_sat) begin
        flag_sat <= 1'b1;
      end
      if (state == S_ADJ && ovfw(adj_t)) begin
        flag_sat <= 1'b1;
      end
      if (state == S_ACC) begin
        if (cls.recip && !cls.xfmr) begin
          ser_re <= clampw(sre_t);
          ser_im <= clampw(sim_t);
          if (ovfw(sre_t) || ovfw(sim_t)) begin
            flag_sat <= 1'b1;
          end
        end
        if (cls.xfmr) begin
          xf_re <= clampw(xre_t);
          xf_im <= clampw(xim_t);
          if (ovfw(xre_t) || ovfw(xim_t)) begin
            flag_sat <= 1'b1;
          end
        end
        if (cls.shunt) begin
          sh_re <= clampw(hre_t);
          sh_im <= clampw(him_t);
          if (ovfw(ti_t) || ovfw(hre_t) || ovfw(him_t)) begin
            flag_sat <= 1'b1;
          end
        end
      end
    end
  end

  // Output register: holds a finished word while the back end moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      series_real  <= ser_re;
      series_imag  <= ser_im;
      xfmr_real    <= xf_re;
      xfmr_imag    <= xf_im;
      shunt_real   <= sh_re;
      shunt_imag   <= sh_im;
      saturated    <= flag_sat;
      zero_divisor <= flag_zero;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/baa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module baa_checker #(
  parameter int WORD_WIDTH = 32
) (
  input wire                  clk,
  input wire                  rst,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire [WORD_WIDTH-1:0] series_real,
  input wire [WORD_WIDTH-1:0] series_imag,
  input wire [WORD_WIDTH-1:0] xfmr_real,
  input wire [WORD_WIDTH-1:0] xfmr_imag,
  input wire [WORD_WIDTH-1:0] shunt_real,
  input wire [WORD_WIDTH-1:0] shunt_imag,
  input wire                  saturated,
  input wire                  zero_divisor
);

  // A result word waits until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // A waiting result word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(series_real) && $stable(series_imag) &&
      $stable(xfmr_real) && $stable(xfmr_imag) && $stable(shunt_real) &&
      $stable(shunt_imag) && $stable(saturated) && $stable(zero_divisor))
    else $error("waiting result word changed");

  // Reset leaves no result pending.
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // Reset empties the input queue, so a word can be taken at once.
  a_rst_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind branch_admittance_accumulator baa_checker #(
  .WORD_WIDTH (WORD_WIDTH)
) u_baa_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .series_real  (series_real),
  .series_imag  (series_imag),
  .xfmr_real    (xfmr_real),
  .xfmr_imag    (xfmr_imag),
  .shunt_real   (shunt_real),
  .shunt_imag   (shunt_imag),
  .saturated    (saturated),
  .zero_divisor (zero_divisor)
);
`default_nettype wire

// ===== dv/branch_admittance_checker.sv =====
`timescale 1ns / 1ps
// Watches both channels of the branch admittance accumulator, predicts each
// result word from the accepted element words, and compares field by field.
module branch_admittance_checker (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  input  wire        in_ready,
  input  wire [31:0] resistance,
  input  wire [31:0] reactance,
  input  wire [31:0] charging,
  input  wire [30:0] tap_ratio,
  input  wire [31:0] shunt_conductance,
  input  wire [31:0] shunt_susceptance,
  input  wire        is_transformer,
  input  wire        in_service,
  input  wire        has_shunt,
  input  wire        at_from_end,
  input  wire        last_element,
  input  wire        out_valid,
  input  wire        out_ready,
  input  wire [31:0] series_real,
  input  wire [31:0] series_imag,
  input  wire [31:0] xfmr_real,
  input  wire [31:0] xfmr_imag,
  input  wire [31:0] shunt_real,
  input  wire [31:0] shunt_imag,
  input  wire        saturated,
  input  wire        zero_divisor,
  output int         errors,
  output int         pending
);

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam int     SCALE_SH = 32;  // 2 * fraction bits

  typedef struct {
    logic [31:0] sr, si, xr, xi, hr, hi;
    logic        sat, zd;
  } stamp_t;

  stamp_t stamp_q[$];

  // Running sums and sticky flags of the branch being accumulated.
  longint ser_re, ser_im, xf_re, xf_im, sh_re, sh_im;
  bit     sat_flag, zero_flag;

  assign pending = stamp_q.size();

  function automatic longint clip(longint v);
    if (v > WMAX) begin
      sat_flag = 1'b1;
      return WMAX;
    end
    if (v < WMIN) begin
      sat_flag = 1'b1;
      return WMIN;
    end
    return v;
  endfunction

  function automatic logic [127:0] mag(longint v);
    logic [127:0] m;
    m = (v < 0) ? 128'(-v) : 128'(v);
    return m;
  endfunction

  // Magnitude quotient, truncated, then clamped to the signed word range.
  function automatic longint quot_sat(logic [127:0] num, logic [127:0] den, bit neg);
    logic [127:0] q;
    logic [127:0] lim;
    q   = num / den;
    lim = neg ? 128'd2147483648 : 128'd2147483647;
    if (q > lim) begin
      sat_flag = 1'b1;
      q = lim;
    end
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  // Negated complex reciprocal -1/(r+jx).
  task automatic neg_admittance(input longint r, input longint x,
                                output longint yr, output longint yi);
    logic [127:0] den;
    den = mag(r) * mag(r) + mag(x) * mag(x);
    yr = 0;
    yi = 0;
    if (den == 0) begin
      zero_flag = 1'b1;
    end else begin
      yr = quot_sat(mag(r) << SCALE_SH, den, r > 0);
      yi = quot_sat(mag(x) << SCALE_SH, den, x < 0);
    end
  endtask

  function automatic longint by_tap_sq(longint v, logic [127:0] den);
    if (den == 0) begin
      if (v == 0) return 0;
      return (v < 0) ? WMIN : WMAX;
    end
    return quot_sat(mag(v) << SCALE_SH, den, v < 0);
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Prediction on every accepted element word.
  always @(posedge clk) begin
    longint r, x, b, gs, bs, half_b, yr, yi, ti;
    logic [127:0] tden;
    stamp_t s;
    if (rst) begin
      ser_re = 0; ser_im = 0; xf_re = 0; xf_im = 0; sh_re = 0; sh_im = 0;
      sat_flag = 0; zero_flag = 0;
    end else if (in_valid && in_ready) begin
      r  = longint'($signed(resistance));
      x  = longint'($signed(reactance));
      b  = longint'($signed(charging));
      gs = longint'($signed(shunt_conductance));
      bs = longint'($signed(shunt_susceptance));
      half_b = b / 2;
      if (in_service && !is_transformer) begin
        neg_admittance(r, x, yr, yi);
        ser_re = clip(ser_re + yr);
        ser_im = clip(ser_im + yi);
      end
      if (in_service && is_transformer) begin
        neg_admittance(r, x, yr, yi);
        yi = clip(yi - half_b);
        if (at_from_end) begin
          tden = 128'(tap_ratio) * 128'(tap_ratio);
          if (tden == 0) zero_flag = 1'b1;
          yr = by_tap_sq(yr, tden);
          yi = by_tap_sq(yi, tden);
        end
        xf_re = clip(xf_re + yr);
        xf_im = clip(xf_im + yi);
      end
      if (in_service && has_shunt) begin
        ti = clip((is_transformer ? 64'sd0 : half_b) + bs);
        sh_re = clip(sh_re + gs);
        sh_im = clip(sh_im + ti);
      end
      if (last_element) begin
        s.sr = ser_re[31:0]; s.si = ser_im[31:0];
        s.xr = xf_re[31:0];  s.xi = xf_im[31:0];
        s.hr = sh_re[31:0];  s.hi = sh_im[31:0];
        s.sat = sat_flag;    s.zd = zero_flag;
        stamp_q.insert(stamp_q.size(), s);
        ser_re = 0; ser_im = 0; xf_re = 0; xf_im = 0; sh_re = 0; sh_im = 0;
        sat_flag = 0; zero_flag = 0;
      end
    end
  end

  // Comparison of every accepted result word with the oldest prediction.
  always @(posedge clk) begin
    stamp_t s;
    if (!rst && out_valid && out_ready) begin
      if (stamp_q.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        errors++;
      end else begin
        s = stamp_q.pop_front();
        if (series_real !== s.sr) report("series_real", series_real, s.sr);
        if (series_imag !== s.si) report("series_imag", series_imag, s.si);
        if (xfmr_real !== s.xr) report("xfmr_real", xfmr_real, s.xr);
        if (xfmr_imag !== s.xi) report("xfmr_imag", xfmr_imag, s.xi);
        if (shunt_real !== s.hr) report("shunt_real", shunt_real, s.hr);
        if (shunt_imag !== s.hi) report("shunt_imag", shunt_imag, s.hi);
        if (saturated !== s.sat) report("saturated", 32'(saturated), 32'(s.sat));
        if (zero_divisor !== s.zd) report("zero_divisor", 32'(zero_divisor), 32'(s.zd));
      end
    end
  end

  initial errors = 0;

endmodule

// ===== dv/branch_admittance_accumulator_tb.sv =====
`timescale 1ns / 1ps
// Drives element words into the accumulator with random gaps on both sides.
module branch_admittance_accumulator_tb;

  localparam int RANDOM_ITEMS = 1850;
  localparam int CYCLE_LIMIT  = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        out_ready = 1'b0;
  logic [31:0] resistance = '0, reactance = '0, charging = '0;
  logic [30:0] tap_ratio = '0;
  logic [31:0] shunt_conductance = '0, shunt_susceptance = '0;
  logic        is_transformer = 0, in_service = 0, has_shunt = 0;
  logic        at_from_end = 0, last_element = 0;
  wire         in_ready, out_valid, saturated, zero_divisor;
  wire  [31:0] series_real, series_imag, xfmr_real, xfmr_imag, shunt_real, shunt_imag;
  int          errors, pending;
  int          cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  branch_admittance_accumulator DUT (.*);
  branch_admittance_checker chk (.*);

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random stall before each result word.
  initial begin
    int gap;
    repeat (3) @(posedge clk);
    forever begin
      gap = $urandom_range(0, 19);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 6))
      0: return $urandom;
      1: return 32'($urandom_range(0, 32'h60000)) - 32'h30000;
      2: return '0;
      3: return 32'h7fffffff;
      4: return 32'h80000000;
      5: return ($urandom & 32'h00ffffff) ^ {32{$urandom_range(0, 1) == 1}};
      default: return 32'($urandom_range(0, 32'h8000)) - 32'h4000;
    endcase
  endfunction

  function automatic logic [30:0] pick_tap();
    case ($urandom_range(0, 5))
      0: return 31'h7fffffff;
      1: return '0;
      2: return 31'($urandom);
      3: return 31'($urandom_range(1, 255));
      default: return 31'($urandom_range(32'he000, 32'h12000));
    endcase
  endfunction

  // Presents one element word after a random gap and waits for acceptance.
  task automatic send(input logic [31:0] r, x, b, input logic [30:0] t,
                      input logic [31:0] g, s, input logic [4:0] fl);
    int gap;
    gap = $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    resistance <= r; reactance <= x; charging <= b; tap_ratio <= t;
    shunt_conductance <= g; shunt_susceptance <= s;
    {is_transformer, in_service, has_shunt, at_from_end, last_element} <= fl;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  initial begin
    logic [4:0] fl;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, zero impedance, zero tap, out of service.
    send(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
         32'h7fffffff, 32'h7fffffff, 5'b01101);
    send(32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff,
         32'h80000000, 32'h80000000, 5'b01101);
    send(32'h1, 32'h0, 32'h80000000, 31'h1, 32'h7fffffff, 32'h80000000, 5'b11111);
    send(32'h0, 32'h0, 32'h0, 31'h10000, 32'h0, 32'h0, 5'b01001);
    send(32'h0, 32'h0, 32'h20000, 31'h0, 32'h0, 32'h0, 5'b11011);
    send(32'h0, 32'h1000, 32'h0, 31'h0, 32'h0, 32'h0, 5'b11011);
    send(32'h1000, 32'h10000, 32'h8000, 31'h10000, 32'h100, 32'h200, 5'b00110);
    send(32'h1000, 32'h10000, 32'h8000, 31'h10000, 32'h100, 32'h200, 5'b00001);
    send(32'h800, 32'h8000, 32'h4000, 31'h11000, 32'h0, 32'h0, 5'b11010);
    send(32'h800, 32'h8000, 32'hffffc000, 31'h0f000, 32'h10, 32'h20, 5'b11100);
    send(32'hfffff000, 32'h00004000, 32'h1, 31'h10000, 32'h1, 32'hffffffff, 5'b01101);
    send(32'h1, 32'h1, 32'h7fffffff, 31'h7fffffff, 32'h0, 32'h0, 5'b11011);
    send(32'h7fffffff, 32'h0, 32'hffffffff, 31'h1, 32'h0, 32'h0, 5'b11011);
    send(32'h1, 32'h0, 32'h0, 31'h0, 32'h7fffffff, 32'h7fffffff, 5'b01100);
    send(32'h1, 32'h0, 32'h0, 31'h0, 32'h7fffffff, 32'h7fffffff, 5'b01101);

    // Random branches: mostly in service, about one element in four is last.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      fl[4] = $urandom_range(0, 1);
      fl[3] = $urandom_range(0, 7) != 0;
      fl[2] = $urandom_range(0, 1);
      fl[1] = $urandom_range(0, 1);
      fl[0] = $urandom_range(0, 3) == 0;
      send(pick_word(), pick_word(), pick_word(), pick_tap(),
           pick_word(), pick_word(), fl);
      if (i == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (160) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // Drain the remaining results, then let the back end settle.
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/baa_pkg.sv
hw/rtl/baa_front.sv
hw/rtl/baa_div.sv
hw/rtl/baa_back.sv
hw/rtl/branch_admittance_accumulator.sv
hw/rtl/baa_checker.sv
dv/branch_admittance_checker.sv
dv/branch_admittance_accumulator_tb.sv
